// ===== src/assert_macros.svh =====
// Assertion helpers for the basis-vector block
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_AT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");
`define ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("assertion failed");
`else
`define ASSERT_AT(lbl, clk, rst, prop)
`define ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

// ===== src/ea2bv_pkg.sv =====
`timescale 1ns / 1ps
package ea2bv_pkg;
   localparam int OUT_FRAC_BITS   = 14;
   localparam int ANGLE_FRAC_BITS = 7;
   localparam int CORDIC_STEPS    = 16;

   localparam int ANGLE_W   = 17;
   localparam int OUT_W     = OUT_FRAC_BITS + 2;
   localparam int WORK_BITS = 30;
   localparam int XW        = WORK_BITS + 3;
   localparam int ZW        = 34;
   localparam int SUMW      = XW + 1;
   localparam int STEPS     = (CORDIC_STEPS < 32) ? CORDIC_STEPS : 32;

   // 360 degrees = 45 * 2^(ANGLE_FRAC_BITS+3)
   localparam int RED_DIV  = 45;
   localparam int ANG_MOD  = 360 << ANGLE_FRAC_BITS;
   localparam int RW       = 16;
   localparam int QW       = ANGLE_FRAC_BITS + 3;
   localparam int SW       = 6;
   localparam int PH_SH    = 29 - ANGLE_FRAC_BITS;
   localparam int RECIP_SH = 30;
   localparam int RECIP    = ((1 << RECIP_SH) + RED_DIV - 1) / RED_DIV;
   localparam int RECIP_W  = 25;
   localparam int GAIN_Q30 = 652032874;
   localparam int SAT_SH   = WORK_BITS - OUT_FRAC_BITS;
   localparam int LAT      = STEPS + 4 + 3;

   // reciprocal of 45 for the fractional binary angle
   localparam int     FRAC_NW    = SW + PH_SH;
   localparam int     FRAC_RW    = 31;
   localparam int     FRAC_SH    = 36;
   localparam longint FRAC_RECIP = ((64'sd1 <<< FRAC_SH) + RED_DIV - 1) / RED_DIV;

   typedef struct packed {
      logic signed [XW-1:0] sn;
      logic signed [XW-1:0] cs;
   } sc_type;

   typedef struct packed {
      logic signed [OUT_W-1:0] fwd_x;
      logic signed [OUT_W-1:0] fwd_y;
      logic signed [OUT_W-1:0] fwd_z;
      logic signed [OUT_W-1:0] rgt_x;
      logic signed [OUT_W-1:0] rgt_y;
      logic signed [OUT_W-1:0] rgt_z;
      logic signed [OUT_W-1:0] upv_x;
      logic signed [OUT_W-1:0] upv_y;
      logic signed [OUT_W-1:0] upv_z;
   } vec_type;

   // arctangent of 2^-i in binary angle units, 2^32 per turn
   function automatic logic [31:0] atan_turn(input int i);
      logic [31:0] v;
      case (i)
         0: v = 32'd536870912;   1: v = 32'd316933406;
         2: v = 32'd167458907;   3: v = 32'd85004756;
         4: v = 32'd42667331;    5: v = 32'd21354465;
         6: v = 32'd10679838;    7: v = 32'd5340245;
         8: v = 32'd2670163;     9: v = 32'd1335087;
         10: v = 32'd667544;     11: v = 32'd333772;
         12: v = 32'd166886;     13: v = 32'd83443;
         14: v = 32'd41722;      15: v = 32'd20861;
         16: v = 32'd10430;      17: v = 32'd5215;
         18: v = 32'd2608;       19: v = 32'd1304;
         20: v = 32'd652;        21: v = 32'd326;
         22: v = 32'd163;        23: v = 32'd81;
         24: v = 32'd41;         25: v = 32'd20;
         26: v = 32'd10;         27: v = 32'd5;
         28: v = 32'd3;          29: v = 32'd1;
         30: v = 32'd1;
         default: v = 32'd0;
      endcase
      return v;
   endfunction

   // fractional part of the binary angle for remainder s of the divide by 45,
   // by multiplication with the rounded-up reciprocal
   function automatic logic [PH_SH-1:0] frac_turn(input logic [SW-1:0] s);
      logic [FRAC_NW-1:0]         n;
      logic [FRAC_NW+FRAC_RW-1:0] t;
      n = (FRAC_NW'(s) << PH_SH) + FRAC_NW'(RED_DIV / 2);
      t = (FRAC_NW+FRAC_RW)'(n) * (FRAC_NW+FRAC_RW)'(FRAC_RECIP);
      return t[FRAC_SH +: PH_SH];
   endfunction

   // Q30 product rounded half up
   function automatic logic signed [XW-1:0] mulq(input logic signed [XW-1:0] a,
                                                 input logic signed [XW-1:0] b);
      logic signed [2*XW-1:0] p;
      p = (2*XW)'(a) * (2*XW)'(b);
      p = p + ((2*XW)'(1) <<< (WORK_BITS - 1));
      p = p >>> WORK_BITS;
      return p[XW-1:0];
   endfunction

   // round to output precision and clamp to +-1.0
   function automatic logic signed [OUT_W-1:0] to_out(input logic signed [SUMW-1:0] v);
      logic signed [SUMW:0] t;
      logic signed [SUMW:0] lim;
      t   = (SUMW+1)'(v) + ((SUMW+1)'(1) <<< (SAT_SH - 1));
      t   = t >>> SAT_SH;
      lim = (SUMW+1)'(1) <<< OUT_FRAC_BITS;
      if (t > lim) t = lim;
      if (t < -lim) t = -lim;
      return t[OUT_W-1:0];
   endfunction
endpackage

// ===== src/ea2bv_if.sv =====
`timescale 1ns / 1ps
interface ea2bv_req_if;
   import ea2bv_pkg::*;
   logic                      valid;
   logic                      ready;
   logic signed [ANGLE_W-1:0] pitch_deg;
   logic signed [ANGLE_W-1:0] yaw_deg;
   logic signed [ANGLE_W-1:0] roll_deg;
   modport source(output valid, pitch_deg, yaw_deg, roll_deg, input ready);
   modport sink(input valid, pitch_deg, yaw_deg, roll_deg, output ready);
endinterface

interface ea2bv_rsp_if;
   import ea2bv_pkg::*;
   logic                    valid;
   logic                    ready;
   logic signed [OUT_W-1:0] fwd_x;
   logic signed [OUT_W-1:0] fwd_y;
   logic signed [OUT_W-1:0] fwd_z;
   logic signed [OUT_W-1:0] rgt_x;
   logic signed [OUT_W-1:0] rgt_y;
   logic signed [OUT_W-1:0] rgt_z;
   logic signed [OUT_W-1:0] upv_x;
   logic signed [OUT_W-1:0] upv_y;
   logic signed [OUT_W-1:0] upv_z;
   modport source(output valid, fwd_x, fwd_y, fwd_z, rgt_x, rgt_y, rgt_z,
                  upv_x, upv_y, upv_z, input ready);
   modport sink(input valid, fwd_x, fwd_y, fwd_z, rgt_x, rgt_y, rgt_z,
                upv_x, upv_y, upv_z, output ready);
endinterface

// ===== src/ea2bv_lane.sv =====
`timescale 1ns / 1ps
module ea2bv_lane
   import ea2bv_pkg::*;
(
   input  logic                      clock,
   input  logic                      en,
   input  logic signed [ANGLE_W-1:0] angle,
   output sc_type                    sc
);
   logic [RW-1:0]           r_ff, r_in;
   logic [RW-1:0]           r1_ff;
   logic [QW-1:0]           qq_ff, qq_in;
   logic signed [ZW-1:0]    z_ff [0:STEPS];
   logic signed [XW-1:0]    x_ff [0:STEPS];
   logic signed [XW-1:0]    y_ff [0:STEPS];
   logic                    flip_ff [0:STEPS];
   logic signed [ANGLE_W+1:0] a_ext, t_add1, t_add2, t_sub1;
   logic [RW+RECIP_W-1:0]   prod;
   logic [RW-1:0]           ss_full;
   logic [31:0]             ph, ph2;
   logic                    flip_in;
   sc_type                  sc_ff;

   // reduce the angle into one turn
   always_comb begin
      a_ext  = (ANGLE_W+2)'(angle);
      t_add1 = a_ext + (ANGLE_W+2)'(ANG_MOD);
      t_add2 = a_ext + (ANGLE_W+2)'(2 * ANG_MOD);
      t_sub1 = a_ext - (ANGLE_W+2)'(ANG_MOD);
      if (a_ext < 0) begin
         r_in = (t_add1 < 0) ? t_add2[RW-1:0] : t_add1[RW-1:0];
      end else if (a_ext >= (ANGLE_W+2)'(ANG_MOD)) begin
         r_in = t_sub1[RW-1:0];
      end else begin
         r_in = a_ext[RW-1:0];
      end
   end

   // quotient by 45 through the reciprocal
   assign prod  = (RW+RECIP_W)'(r_ff) * (RW+RECIP_W)'(RECIP);
   assign qq_in = prod[RECIP_SH +: QW];

   // binary angle, fold second and third quadrant
   always_comb begin
      ss_full = r1_ff - RW'(qq_ff * RW'(RED_DIV));
      ph      = (32'(qq_ff) << PH_SH) + 32'(frac_turn(ss_full[SW-1:0]));
      flip_in = (ph[31:30] == 2'b01) || (ph[31:30] == 2'b10);
      ph2     = flip_in ? ph - 32'h8000_0000 : ph;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         r_ff       <= r_in;
         r1_ff      <= r_ff;
         qq_ff      <= qq_in;
         z_ff[0]    <= ZW'($signed(ph2));
         x_ff[0]    <= XW'(GAIN_Q30);
         y_ff[0]    <= '0;
         flip_ff[0] <= flip_in;
      end
   end

   // one rotation per stage
   for (genvar i = 0; i < STEPS; i++) begin : g_step
      always_ff @(posedge clock) begin
         if (en) begin
            flip_ff[i+1] <= flip_ff[i];
            if (z_ff[i] >= 0) begin
               x_ff[i+1] <= x_ff[i] - (y_ff[i] >>> i);
               y_ff[i+1] <= y_ff[i] + (x_ff[i] >>> i);
               z_ff[i+1] <= z_ff[i] - ZW'(atan_turn(i));
            end else begin
               x_ff[i+1] <= x_ff[i] + (y_ff[i] >>> i);
               y_ff[i+1] <= y_ff[i] - (x_ff[i] >>> i);
               z_ff[i+1] <= z_ff[i] + ZW'(atan_turn(i));
            end
         end
      end
   end

   // undo the half-turn fold
   always_ff @(posedge clock) begin
      if (en) begin
         sc_ff.sn <= flip_ff[STEPS] ? -y_ff[STEPS] : y_ff[STEPS];
         sc_ff.cs <= flip_ff[STEPS] ? -x_ff[STEPS] : x_ff[STEPS];
      end
   end

   assign sc = sc_ff;
endmodule

// ===== src/ea2bv_merge.sv =====
`timescale 1ns / 1ps
module ea2bv_merge
   import ea2bv_pkg::*;
(
   input  logic    clock,
   input  logic    en,
   input  sc_type  pit,
   input  sc_type  yaw,
   input  sc_type  rol,
   output vec_type vec
);
   logic signed [XW-1:0] srsp_ff, crsp_ff, cpcy_ff, cpsy_ff, crsy_ff, crcy_ff;
   logic signed [XW-1:0] srcp_ff, srsy_ff, srcy_ff, crcp_ff, sp_ff, sy_ff, cy_ff;
   logic signed [XW-1:0] a_cpcy_ff, a_cpsy_ff, a_crsy_ff, a_crcy_ff, a_srcp_ff;
   logic signed [XW-1:0] a_srsy_ff, a_srcy_ff, a_crcp_ff, a_sp_ff;
   logic signed [XW-1:0] srspcy_ff, srspsy_ff, crspcy_ff, crspsy_ff;
   vec_type              vec_ff;

   // first products
   always_ff @(posedge clock) begin
      if (en) begin
         srsp_ff <= mulq(rol.sn, pit.sn);
         crsp_ff <= mulq(rol.cs, pit.sn);
         cpcy_ff <= mulq(pit.cs, yaw.cs);
         cpsy_ff <= mulq(pit.cs, yaw.sn);
         crsy_ff <= mulq(rol.cs, yaw.sn);
         crcy_ff <= mulq(rol.cs, yaw.cs);
         srcp_ff <= mulq(rol.sn, pit.cs);
         srsy_ff <= mulq(rol.sn, yaw.sn);
         srcy_ff <= mulq(rol.sn, yaw.cs);
         crcp_ff <= mulq(rol.cs, pit.cs);
         sp_ff   <= pit.sn;
         sy_ff   <= yaw.sn;
         cy_ff   <= yaw.cs;
      end
   end

   // triple products, carry the rest along
   always_ff @(posedge clock) begin
      if (en) begin
         srspcy_ff <= mulq(srsp_ff, cy_ff);
         srspsy_ff <= mulq(srsp_ff, sy_ff);
         crspcy_ff <= mulq(crsp_ff, cy_ff);
         crspsy_ff <= mulq(crsp_ff, sy_ff);
         a_cpcy_ff <= cpcy_ff;
         a_cpsy_ff <= cpsy_ff;
         a_crsy_ff <= crsy_ff;
         a_crcy_ff <= crcy_ff;
         a_srcp_ff <= srcp_ff;
         a_srsy_ff <= srsy_ff;
         a_srcy_ff <= srcy_ff;
         a_crcp_ff <= crcp_ff;
         a_sp_ff   <= sp_ff;
      end
   end

   // sum, round and saturate into the output register
   always_ff @(posedge clock) begin
      if (en) begin
         vec_ff.fwd_x <= to_out(SUMW'(a_cpcy_ff));
         vec_ff.fwd_y <= to_out(SUMW'(a_cpsy_ff));
         vec_ff.fwd_z <= to_out(-SUMW'(a_sp_ff));
         vec_ff.rgt_x <= to_out(SUMW'(a_crsy_ff) - SUMW'(srspcy_ff));
         vec_ff.rgt_y <= to_out(-SUMW'(srspsy_ff) - SUMW'(a_crcy_ff));
         vec_ff.rgt_z <= to_out(-SUMW'(a_srcp_ff));
         vec_ff.upv_x <= to_out(SUMW'(crspcy_ff) + SUMW'(a_srsy_ff));
         vec_ff.upv_y <= to_out(SUMW'(crspsy_ff) - SUMW'(a_srcy_ff));
         vec_ff.upv_z <= to_out(SUMW'(a_crcp_ff));
      end
   end

   assign vec = vec_ff;
endmodule

// ===== src/euler_angles_to_basis_vectors_top.sv =====
// Throughput: one item per cycle while results are accepted; three CORDIC lanes, one rotation stage each step.
// The whole pipeline advances together and holds while a result waits unaccepted.
// Reset (synchronous, active high) clears all stage valid bits; data is not reset.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module euler_angles_to_basis_vectors_top
   import ea2bv_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   ea2bv_req_if.sink   req,
   ea2bv_rsp_if.source rsp
);
   logic [LAT-1:0] vld_ff, vld_in;
   logic           en;
   sc_type         sc_pit, sc_yaw, sc_rol;
   vec_type        vec;

   // advance unless a result is stuck at the output
   assign en        = !(vld_ff[LAT-1] && !rsp.ready);
   assign req.ready = en;

   // track valid items through the stages
   always_comb begin
      vld_in = vld_ff;
      if (en) begin
         vld_in = {vld_ff[LAT-2:0], req.valid};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   ea2bv_lane u_pit (.clock(clock), .en(en), .angle(req.pitch_deg), .sc(sc_pit));
   ea2bv_lane u_yaw (.clock(clock), .en(en), .angle(req.yaw_deg),   .sc(sc_yaw));
   ea2bv_lane u_rol (.clock(clock), .en(en), .angle(req.roll_deg),  .sc(sc_rol));

   ea2bv_merge u_merge (
      .clock(clock),
      .en   (en),
      .pit  (sc_pit),
      .yaw  (sc_yaw),
      .rol  (sc_rol),
      .vec  (vec)
   );

   assign rsp.valid = vld_ff[LAT-1];
   assign rsp.fwd_x = vec.fwd_x;
   assign rsp.fwd_y = vec.fwd_y;
   assign rsp.fwd_z = vec.fwd_z;
   assign rsp.rgt_x = vec.rgt_x;
   assign rsp.rgt_y = vec.rgt_y;
   assign rsp.rgt_z = vec.rgt_z;
   assign rsp.upv_x = vec.upv_x;
   assign rsp.upv_y = vec.upv_y;
   assign rsp.upv_z = vec.upv_z;

   `ASSERT_AT(a_ready_stall, clock, reset, req.ready == !(rsp.valid && !rsp.ready))
   `ASSERT_AT(a_fwd_z_sat, clock, reset, rsp.valid |-> (rsp.fwd_z <= 16'sd16384 && rsp.fwd_z >= -16'sd16384))
   `ASSERT_AT(a_upv_z_sat, clock, reset, rsp.valid |-> (rsp.upv_z <= 16'sd16384 && rsp.upv_z >= -16'sd16384))
   `ASSERT_AT(a_stall_hold, clock, reset, (rsp.valid && !rsp.ready) |=> $stable(vld_ff))
endmodule
